@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the PWM capture unit.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge.
`define PDC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PDC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pdc_pkg.sv @@
// Shared types and constants of the PWM period and duty capture unit.
// No dependencies.
`timescale 1ns / 1ps

package pdc_pkg;

    localparam int CAP_W      = 16;    // capture_count field
    localparam int US_W       = 40;    // microsecond results
    localparam int TICK_W     = 8;     // tick_us register
    localparam int TICK_CNT_W = 3;     // steps of the serial scaler
    localparam int FREQ_W     = 27;
    localparam int DUTY_W     = 10;
    localparam int DIV_CNT_W  = 5;     // holds FREQ_W iterations
    localparam int NUMF_W     = US_W + 1;
    localparam int NUMD_W     = US_W + DUTY_W + 1;

    localparam logic [US_W-1:0]   US_MAX     = {US_W{1'b1}};
    localparam logic [FREQ_W-1:0] FREQ_SCALE = 27'd100000000;  // centihertz per 1/us
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 10'd1000;
    localparam logic [TICK_W-1:0] TICK_RESET = 8'd4;

    // Request kinds on the input tuser
    localparam logic REQ_OVERFLOW = 1'b0;
    localparam logic REQ_CAPTURE  = 1'b1;

    // APB word index of the tick_us register
    localparam logic ADDR_TICK = 1'b0;

    // Result item; done_res lands in the lowest bit of tdata
    typedef struct packed {
        logic              range_error;
        logic [DUTY_W-1:0] duty_permille;
        logic [FREQ_W-1:0] freq_centihz;
        logic [US_W-1:0]   off_time_us;
        logic [US_W-1:0]   on_time_us;
        logic [US_W-1:0]   period_us;
        logic              arm_rising;
        logic              done_res;
    } res_t;

    localparam int TDATA_W = $bits(res_t);

    typedef struct packed {
        logic                 start;
        logic [US_W-1:0]      rem;    // numerator bits above the quotient span
        logic [FREQ_W-1:0]    nsh;    // remaining numerator bits, MSB first
        logic [DIV_CNT_W-1:0] iters;
        logic [US_W-1:0]      den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FREQ_W-1:0] quo;
    } div_rsp_t;

endpackage

@@ hdl/pdc_scale.sv @@
// Bit-serial scaler: converts period and on-time tick counts to microseconds.
// Shift-add over the tick_us bits, MSB first, saturating at 40 bits. Uses pdc_pkg.
`timescale 1ns / 1ps

module pdc_scale
    import pdc_pkg::*;
#(
    parameter int SW = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SW-1:0]     per_ticks,
    input  logic [SW-1:0]     on_ticks,
    input  logic [TICK_W-1:0] tick_us,
    output logic              done,
    output logic [US_W-1:0]   per_us,
    output logic [US_W-1:0]   on_us
);

    localparam int PW = (SW + TICK_W > US_W + 1) ? SW + TICK_W : US_W + 1;

    logic [PW-1:0]         per_acc_reg, per_acc_next;
    logic [PW-1:0]         on_acc_reg, on_acc_next;
    logic [SW-1:0]         per_x_reg, per_x_next;
    logic [SW-1:0]         on_x_reg, on_x_next;
    logic [TICK_W-1:0]     tsh_reg, tsh_next;
    logic [TICK_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb begin
        per_acc_next = per_acc_reg;
        on_acc_next  = on_acc_reg;
        per_x_next   = per_x_reg;
        on_x_next    = on_x_reg;
        tsh_next     = tsh_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start) begin
            per_acc_next = '0;
            on_acc_next  = '0;
            per_x_next   = per_ticks;
            on_x_next    = on_ticks;
            tsh_next     = tick_us;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            per_acc_next = {per_acc_reg[PW-2:0], 1'b0}
                         + (tsh_reg[TICK_W-1] ? PW'(per_x_reg) : '0);
            on_acc_next  = {on_acc_reg[PW-2:0], 1'b0}
                         + (tsh_reg[TICK_W-1] ? PW'(on_x_reg) : '0);
            tsh_next     = {tsh_reg[TICK_W-2:0], 1'b0};
            cnt_next     = cnt_reg + 1'b1;
            if (cnt_reg == TICK_CNT_W'(TICK_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        per_acc_reg <= per_acc_next;
        on_acc_reg  <= on_acc_next;
        per_x_reg   <= per_x_next;
        on_x_reg    <= on_x_next;
        tsh_reg     <= tsh_next;
    end

    // Clamp anything past 40 bits to the top value
    assign per_us = (|per_acc_reg[PW-1:US_W]) ? US_MAX : per_acc_reg[US_W-1:0];
    assign on_us  = (|on_acc_reg[PW-1:US_W])  ? US_MAX : on_acc_reg[US_W-1:0];
    assign done   = done_reg;

endmodule

@@ hdl/pdc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Serves both the frequency and the duty division. Uses pdc_pkg.
`timescale 1ns / 1ps

module pdc_div
    import pdc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [US_W-1:0]      rem_reg, rem_next;
    logic [FREQ_W-1:0]    nsh_reg, nsh_next;
    logic [US_W-1:0]      den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [US_W:0]        trial;
    logic                 fits;

    assign trial = {rem_reg, nsh_reg[FREQ_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        nsh_next  = nsh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem;
            nsh_next  = req.nsh;
            den_next  = req.den;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits back in US_W bits
            rem_next = fits ? US_W'(trial - {1'b0, den_reg}) : trial[US_W-1:0];
            nsh_next = {nsh_reg[FREQ_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        nsh_reg <= nsh_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = nsh_reg;

endmodule

@@ hdl/pdc_ctrl.sv @@
// Sequencer of the PWM capture unit: overflow count, capture phases,
// time stamps, and the steps of one measurement. Uses pdc_pkg.
`timescale 1ns / 1ps

module pdc_ctrl
    import pdc_pkg::*;
#(
    parameter int TIMER_BITS    = 16,
    parameter int OVERFLOW_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                req_type,
    input  logic [CAP_W-1:0]                    capture_count,
    output logic                                scale_start,
    output logic [TIMER_BITS+OVERFLOW_BITS-1:0] scale_per,
    output logic [TIMER_BITS+OVERFLOW_BITS-1:0] scale_on,
    input  logic                                scale_done,
    input  logic [US_W-1:0]                     scale_per_us,
    input  logic [US_W-1:0]                     scale_on_us,
    output div_req_t                            div_req,
    input  div_rsp_t                            div_rsp,
    output logic                                res_valid,
    output res_t                                res,
    input  logic                                res_take
);

    localparam int SW = TIMER_BITS + OVERFLOW_BITS;
    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = {OVERFLOW_BITS{1'b1}};

    localparam logic [1:0] PH_RISE  = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_NEXT  = 2'd2;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_DIFF  = 11'b000_0000_0010,
        ST_CLAMP = 11'b000_0000_0100,
        ST_MUL   = 11'b000_0000_1000,
        ST_PREP  = 11'b000_0001_0000,
        ST_FLOAD = 11'b000_0010_0000,
        ST_FWAIT = 11'b000_0100_0000,
        ST_DLOAD = 11'b000_1000_0000,
        ST_DWAIT = 11'b001_0000_0000,
        ST_EMIT  = 11'b010_0000_0000,
        ST_ZERO  = 11'b100_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [1:0]               phase_reg, phase_next;
    logic [OVERFLOW_BITS-1:0] ovf_reg, ovf_next;
    logic                     sat_reg, sat_next;
    logic [SW-1:0]            first_reg, first_next;
    logic [SW-1:0]            second_reg, second_next;
    logic [SW-1:0]            third_reg, third_next;
    logic [SW-1:0]            per_t_reg, per_t_next;
    logic [SW-1:0]            on_t_reg, on_t_next;
    logic [NUMF_W-1:0]        numf_reg, numf_next;
    logic [NUMD_W-1:0]        onk_reg, onk_next;
    logic [NUMD_W-1:0]        numd_reg, numd_next;
    res_t                     res_reg, res_next;

    logic [TIMER_BITS+CAP_W-1:0] cap_wide;
    logic [SW-1:0]               stamp;
    logic [NUMD_W-1:0]           on_wide;

    assign cap_wide = {{TIMER_BITS{1'b0}}, capture_count};
    assign stamp    = {ovf_reg, cap_wide[TIMER_BITS-1:0]};
    assign on_wide  = NUMD_W'(res_reg.on_time_us);

    assign scale_per = per_t_reg;
    // An on time past the period is cut back to the period
    assign scale_on  = (on_t_reg > per_t_reg) ? per_t_reg : on_t_reg;

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        ovf_next    = ovf_reg;
        sat_next    = sat_reg;
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        per_t_next  = per_t_reg;
        on_t_next   = on_t_reg;
        numf_next   = numf_reg;
        onk_next    = onk_reg;
        numd_next   = numd_reg;
        res_next    = res_reg;
        scale_start = 1'b0;
        div_req     = '0;
        div_req.den = res_reg.period_us;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_next             = '0;
                    res_next.range_error = sat_reg;
                    res_next.arm_rising  = 1'b1;
                    state_next           = ST_EMIT;
                    if (req_type == REQ_OVERFLOW) begin
                        if (ovf_reg == OVF_MAX) begin
                            sat_next             = 1'b1;
                            res_next.range_error = 1'b1;
                        end else begin
                            ovf_next = ovf_reg + 1'b1;
                        end
                        res_next.arm_rising = (phase_reg != PH_FALL);
                    end else begin
                        case (phase_reg)
                            PH_RISE: begin
                                first_next          = stamp;
                                phase_next          = PH_FALL;
                                res_next.arm_rising = 1'b0;
                            end
                            PH_FALL: begin
                                second_next = stamp;
                                phase_next  = PH_NEXT;
                            end
                            PH_NEXT: begin
                                third_next        = stamp;
                                phase_next        = PH_RISE;
                                ovf_next          = '0;
                                sat_next          = 1'b0;
                                res_next.done_res = 1'b1;
                                state_next        = ST_DIFF;
                            end
                            default: begin
                                phase_next = PH_RISE;
                            end
                        endcase
                    end
                end
            end
            ST_DIFF: begin
                // wrap modulo the stamp width
                per_t_next = third_reg - first_reg;
                on_t_next  = second_reg - first_reg;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                scale_start = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                if (scale_done) begin
                    res_next.period_us  = scale_per_us;
                    res_next.on_time_us = scale_on_us;
                    state_next          = ST_PREP;
                end
            end
            ST_PREP: begin
                res_next.off_time_us = res_reg.period_us - res_reg.on_time_us;
                numf_next = NUMF_W'(FREQ_SCALE) + NUMF_W'(res_reg.period_us >> 1);
                // times 1000 as 1024 - 16 - 8
                onk_next  = (on_wide << 10) - (on_wide << 4) - (on_wide << 3);
                state_next = (res_reg.period_us == '0) ? ST_ZERO : ST_FLOAD;
            end
            ST_ZERO: begin
                state_next = ST_EMIT;
            end
            ST_FLOAD: begin
                div_req.start = 1'b1;
                div_req.rem   = US_W'(numf_reg >> FREQ_W);
                div_req.nsh   = numf_reg[FREQ_W-1:0];
                div_req.iters = DIV_CNT_W'(FREQ_W);
                numd_next     = onk_reg + NUMD_W'(res_reg.period_us >> 1);
                state_next    = ST_FWAIT;
            end
            ST_FWAIT: begin
                if (div_rsp.done) begin
                    res_next.freq_centihz = div_rsp.quo;
                    state_next            = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                div_req.start = 1'b1;
                div_req.rem   = US_W'(numd_reg >> DUTY_W);
                div_req.nsh   = {numd_reg[DUTY_W-1:0], {(FREQ_W - DUTY_W){1'b0}}};
                div_req.iters = DIV_CNT_W'(DUTY_W);
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    res_next.duty_permille = div_rsp.quo[DUTY_W-1:0];
                    state_next             = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_RISE;
            ovf_reg    <= '0;
            sat_reg    <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ovf_reg    <= ovf_next;
            sat_reg    <= sat_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
        third_reg <= third_next;
        per_t_reg <= per_t_next;
        on_t_reg  <= on_t_next;
        numf_reg  <= numf_next;
        onk_reg   <= onk_next;
        numd_reg  <= numd_next;
        res_reg   <= res_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

endmodule

@@ hdl/pdc_outreg.sv @@
// Output register of the PWM capture unit: holds one item for the m_ side
// so the sequencer can move on while the receiver stalls. Uses pdc_pkg.
`timescale 1ns / 1ps

module pdc_outreg
    import pdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    input  res_t               res,
    output logic               res_take,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;

    // Take a new item when the register is empty or drains this cycle
    assign res_take = res_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_take) begin
            valid_next = 1'b1;
            data_next  = res;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

@@ hdl/pwm_period_duty_capture_unit.sv @@
// PWM period and duty capture unit, top level. Uses pdc_pkg, pdc_ctrl,
// pdc_scale, pdc_div, pdc_outreg and assert_macros.svh.
//
// The s_ channel takes timer events: s_tuser says overflow tick (0) or edge
// capture (1), s_tdata carries the latched timer count. Each event gives one
// item on the m_ channel. Rising, falling and next rising captures form one
// measurement; the third one yields period, on and off time in microseconds,
// frequency in centihertz and duty in permille, with done_res set to restart
// the timer. tick_us (microseconds per tick) sits at APB address 0.
// A tick or one of the first two captures goes through the sequencer's emit
// state into the output register, which raises m_tvalid. A completing capture
// runs 8 steps of the bit-serial scaler (one tick_us bit each) and 37 steps of
// the shared radix-2 divider (27 frequency bits, 10 duty bits) before its
// result shows. A zero period skips the divider.
// One finished item waits in the output register while the next one is
// accepted and worked; a further result then holds until m_tready frees it.
// Reset clears phase, overflow count and range flag and sets tick_us to 4.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwm_period_duty_capture_unit
    import pdc_pkg::*;
#(
    parameter int TIMER_BITS    = 16,
    parameter int OVERFLOW_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CAP_W-1:0]   s_tdata,   // [15:0] capture_count
    input  logic               s_tuser,   // [0] req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    // [0] done_res, [1] arm_rising, [41:2] period_us, [81:42] on_time_us,
    // [121:82] off_time_us, [148:122] freq_centihz, [158:149] duty_permille,
    // [159] range_error
    output logic [TDATA_W-1:0] m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SW = TIMER_BITS + OVERFLOW_BITS;

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              cfg_wr;
    logic              scale_start;
    logic [SW-1:0]     scale_per;
    logic [SW-1:0]     scale_on;
    logic              scale_done;
    logic [US_W-1:0]   scale_per_us;
    logic [US_W-1:0]   scale_on_us;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic              res_valid;
    res_t              res;
    logic              res_take;
    res_t              m_view;

    // Register decode on the word index; byte offset ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_TICK);
    assign tick_next = cfg_wr ? pwdata[TICK_W-1:0] : tick_reg;
    assign prdata = (paddr[2] == ADDR_TICK) ? 32'(tick_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= TICK_RESET;
        end else begin
            tick_reg <= tick_next;
        end
    end

    pdc_ctrl #(
        .TIMER_BITS    (TIMER_BITS),
        .OVERFLOW_BITS (OVERFLOW_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser),
        .capture_count (s_tdata),
        .scale_start   (scale_start),
        .scale_per     (scale_per),
        .scale_on      (scale_on),
        .scale_done    (scale_done),
        .scale_per_us  (scale_per_us),
        .scale_on_us   (scale_on_us),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take)
    );

    pdc_scale #(
        .SW (SW)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scale_start),
        .per_ticks (scale_per),
        .on_ticks  (scale_on),
        .tick_us   (tick_reg),
        .done      (scale_done),
        .per_us    (scale_per_us),
        .on_us     (scale_on_us)
    );

    pdc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pdc_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign m_view = m_tdata;

    `PDC_ASSERT_IMPL(a_idle_fields_zero, m_tvalid && !m_view.done_res, (m_view.period_us == '0) && (m_view.on_time_us == '0) && (m_view.freq_centihz == '0) && (m_view.duty_permille == '0), "measurement fields set without done_res")
    `PDC_ASSERT_IMPL(a_done_arms_rising, m_tvalid && m_view.done_res, m_view.arm_rising, "completed measurement must arm the rising edge")
    `PDC_ASSERT_IMPL(a_result_ranges, m_tvalid, (m_view.duty_permille <= DUTY_FULL) && (m_view.freq_centihz <= FREQ_SCALE) && (m_view.off_time_us <= m_view.period_us), "result field out of range")
    `PDC_ASSERT_NEXT(a_busy_after_capture, s_tvalid && s_tready && (s_tuser == REQ_CAPTURE), !s_tready, "input taken again right after a capture")

endmodule
